// File: hw/rtl/breath_pressure_detector_macros.svh
// Assertion macros used by the top-level RTL file, which checks itself.
`ifndef BREATH_PRESSURE_DETECTOR_MACROS_SVH
`define BREATH_PRESSURE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define BPD_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define BPD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define BPD_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`define BPD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// File: hw/rtl/bpd_pkg.sv
`default_nettype none
package bpd_pkg;

  // Window and sample sizing
  localparam int WINDOW_LEN  = 10;
  localparam int SAMPLE_BITS = 12;

  // Fixed register widths
  localparam int BASE_W   = 12;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 20;
  localparam int STABLE_W = 8;
  localparam int LEVEL_W  = 21;
  localparam int GLVL_W   = 7;

  // Derived widths
  localparam int EXT_W   = (SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W;
  localparam int DELTA_W = EXT_W + 1;
  localparam int SUM_W   = DELTA_W + $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int GAS_W   = EXT_W;
  localparam int GNUM_W  = GAS_W + GLVL_W;
  localparam int PROD_W  = SUM_W + GAIN_W + 1;
  localparam int SH_W    = PROD_W - 8;

  // Shared serial divider
  localparam int DIV_NUM_W = (SUM_W > GNUM_W) ? SUM_W : GNUM_W;
  localparam int DIV_DEN_W = (CNT_W > GAS_W) ? CNT_W : GAS_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_BASELINE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_REQUIRED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_BASELINE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_DELTA_MIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_DELTA_MAX      = 3'd6;

  localparam logic [GLVL_W-1:0] GAS_LEVEL_FULL = 7'd100;

  // Configuration register set
  typedef struct packed {
    logic [BASE_W-1:0]   pressure_baseline;
    logic [GAIN_W-1:0]   pressure_gain;
    logic [THR_W-1:0]    pressure_threshold;
    logic [STABLE_W-1:0] stable_required;
    logic [BASE_W-1:0]   gas_baseline;
    logic [BASE_W-1:0]   gas_delta_min;
    logic [BASE_W-1:0]   gas_delta_max;
  } bpd_cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic [SAMPLE_BITS-1:0]  gas;
  } bpd_item_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PDIV,
    BK_MUL,
    BK_SCALE,
    BK_GDIV,
    BK_DONE
  } bpd_back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/bpd_in_if.sv
`default_nettype none
interface bpd_in_if import bpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pressure_sample;
  logic [SAMPLE_BITS-1:0] gas_sample;

  modport source (output valid, output pressure_sample, output gas_sample, input ready);
  modport sink   (input valid, input pressure_sample, input gas_sample, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpd_out_if.sv
`default_nettype none
interface bpd_out_if import bpd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      blowing;
  logic signed [LEVEL_W-1:0] pressure_level;
  logic [GLVL_W-1:0]         gas_level;

  modport source (output valid, output blowing, output pressure_level, output gas_level,
                  input ready);
  modport sink   (input valid, input blowing, input pressure_level, input gas_level,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpd_cfg_if.sv
`default_nettype none
interface bpd_cfg_if import bpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/breath_pressure_detector.sv
// Each request's average is found by the shared serial divider, which is used again for
// the gas level when that is interpolated. The single divider (one quotient bit per cycle)
// serves both divides, so the back end takes a new request only once it is through with
// the last one. A two-entry queue lets the front accept while the back still works.
// Reset (rst, synchronous, active high) clears the window, run counter, flag and queue
// and loads the register defaults; no clearing pass is needed.
`default_nettype none
`include "breath_pressure_detector_macros.svh"
module breath_pressure_detector import bpd_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  bpd_in_if.sink    samples,
  bpd_out_if.source results,
  bpd_cfg_if.sink   cfg
);

  bpd_cfg_t  regs;
  logic      q_push_valid;
  logic      q_push_ready;
  bpd_item_t q_push_data;
  logic      q_valid;
  logic      q_ready;
  bpd_item_t q_data;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pressure_baseline  <= BASE_W'(0);
      regs.pressure_gain      <= GAIN_W'(14855);
      regs.pressure_threshold <= THR_W'(256);
      regs.stable_required    <= STABLE_W'(5);
      regs.gas_baseline       <= BASE_W'(0);
      regs.gas_delta_min      <= BASE_W'(30);
      regs.gas_delta_max      <= BASE_W'(800);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PRESSURE_BASELINE:  regs.pressure_baseline  <= cfg.data[BASE_W-1:0];
        CFG_PRESSURE_GAIN:      regs.pressure_gain      <= cfg.data[GAIN_W-1:0];
        CFG_PRESSURE_THRESHOLD: regs.pressure_threshold <= cfg.data[THR_W-1:0];
        CFG_STABLE_REQUIRED:    regs.stable_required    <= cfg.data[STABLE_W-1:0];
        CFG_GAS_BASELINE:       regs.gas_baseline       <= cfg.data[BASE_W-1:0];
        CFG_GAS_DELTA_MIN:      regs.gas_delta_min      <= cfg.data[BASE_W-1:0];
        CFG_GAS_DELTA_MAX:      regs.gas_delta_max      <= cfg.data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  bpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .samples    (samples),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  bpd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  bpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data),
    .results   (results)
  );

  // Idle results carry zero levels
  `BPD_ASSERT_IMPLIES(a_idle_zero, clk, rst, results.valid && !results.blowing, results.pressure_level == '0 && results.gas_level == '0)
  // Gas level never exceeds full scale
  `BPD_ASSERT_IMPLIES(a_gas_range, clk, rst, results.valid, results.gas_level <= GAS_LEVEL_FULL)
  // Blowing implies filtered pressure above threshold
  `BPD_ASSERT_IMPLIES(a_blow_above, clk, rst, results.valid && results.blowing, results.pressure_level > $signed({1'b0, regs.pressure_threshold}))
  // An accepted request is queued on the next cycle
  `BPD_ASSERT_NEXT(a_queued, clk, rst, samples.valid && samples.ready, q_valid)

endmodule
`default_nettype wire

// File: hw/rtl/bpd_front.sv
`default_nettype none
module bpd_front import bpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  bpd_cfg_t   cfg,
  bpd_in_if.sink     samples,
  output logic       push_valid,
  input  wire logic  push_ready,
  output bpd_item_t  push_data
);

  logic signed [DELTA_W-1:0] window [WINDOW_LEN];
  logic signed [SUM_W-1:0]   running_sum;
  logic [SLOT_W-1:0]         write_slot;
  logic                      window_full;

  logic                      accept;
  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] oldest;
  logic signed [SUM_W-1:0]   sum_next;
  logic                      wrap;
  logic [CNT_W-1:0]          count;

  assign accept        = samples.valid && push_ready;
  assign samples.ready = push_ready;
  assign push_valid    = samples.valid;

  // Pressure delta against baseline
  assign delta = $signed({1'b0, EXT_W'(samples.pressure_sample)})
               - $signed({1'b0, EXT_W'(cfg.pressure_baseline)});

  // Slots not yet written read as zero until the window first fills
  assign oldest   = window_full ? window[write_slot] : '0;
  assign sum_next = running_sum - SUM_W'(oldest) + SUM_W'(delta);
  assign wrap     = (write_slot == SLOT_W'(WINDOW_LEN - 1));
  assign count    = window_full ? CNT_W'(WINDOW_LEN) : CNT_W'(write_slot) + CNT_W'(1);

  assign push_data.sum = sum_next;
  assign push_data.cnt = count;
  assign push_data.gas = samples.gas_sample;

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      write_slot  <= '0;
      window_full <= 1'b0;
    end else if (accept) begin
      running_sum <= sum_next;
      write_slot  <= wrap ? '0 : write_slot + SLOT_W'(1);
      if (wrap) begin
        window_full <= 1'b1;
      end
    end
  end

  // Delta storage
  always_ff @(posedge clk) begin
    if (accept) begin
      window[write_slot] <= delta;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bpd_fifo.sv
`default_nettype none
module bpd_fifo import bpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  bpd_item_t  push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output bpd_item_t  pop_data
);

  bpd_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bpd_div.sv
`default_nettype none
module bpd_div import bpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  // One quotient bit per cycle, restoring
  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bpd_back.sv
`default_nettype none
module bpd_back import bpd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  bpd_cfg_t   cfg,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  bpd_item_t  pop_data,
  bpd_out_if.source  results
);

  bpd_back_state_t state, state_next;

  logic                      div_start;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_quo;
  logic                      ld_out;

  logic                      neg;
  logic [SAMPLE_BITS-1:0]    gas_r;
  logic signed [SUM_W-1:0]   avg;
  logic signed [PROD_W-1:0]  prod;
  logic signed [LEVEL_W-1:0] filtered;
  logic [GLVL_W-1:0]         gas_lvl;
  logic [STABLE_W-1:0]       above_run;
  logic                      blow_flag;
  logic                      out_valid;

  logic [SUM_W-1:0]          sum_mag;
  logic [SUM_W-1:0]          quo_p;
  logic signed [SH_W-1:0]    shifted;
  logic                      sat;
  logic signed [LEVEL_W-1:0] sat_val;
  logic                      above;
  logic [STABLE_W-1:0]       run_new;
  logic                      blow_new;
  logic [GAS_W-1:0]          gs_ext;
  logic [GAS_W-1:0]          gb_ext;
  logic [GAS_W-1:0]          g_min;
  logic [GAS_W-1:0]          g_max;
  logic [GAS_W-1:0]          g_delta;
  logic                      gas_need_div;
  logic [GLVL_W-1:0]         gas_fixed;
  logic [GNUM_W-1:0]         gas_num;

  bpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Magnitude for the average divide
  assign sum_mag = pop_data.sum[SUM_W-1] ? SUM_W'(-pop_data.sum) : SUM_W'(pop_data.sum);
  assign quo_p   = div_quo[SUM_W-1:0];

  // Floor shift by 8 then clamp to 21 bits
  assign shifted = prod[PROD_W-1:8];
  assign sat     = !((&shifted[SH_W-1:LEVEL_W-1]) || !(|shifted[SH_W-1:LEVEL_W-1]));
  assign sat_val = shifted[SH_W-1] ? {1'b1, {(LEVEL_W-1){1'b0}}}
                                   : {1'b0, {(LEVEL_W-1){1'b1}}};

  // Debounce; an already set flag holds while the run stays above threshold
  assign above    = (sat ? sat_val : $signed(shifted[LEVEL_W-1:0]))
                  > $signed({1'b0, cfg.pressure_threshold});
  assign run_new  = !above ? '0 :
                    (above_run < cfg.stable_required) ? above_run + STABLE_W'(1) : above_run;
  assign blow_new = above && (blow_flag || (run_new >= cfg.stable_required));

  // Gas mapping
  assign gs_ext  = GAS_W'(gas_r);
  assign gb_ext  = GAS_W'(cfg.gas_baseline);
  assign g_min   = GAS_W'(cfg.gas_delta_min);
  assign g_max   = GAS_W'(cfg.gas_delta_max);
  assign g_delta = (gs_ext > gb_ext) ? gs_ext - gb_ext : '0;
  assign gas_num = GNUM_W'(g_delta - g_min) * GNUM_W'(GAS_LEVEL_FULL);

  always_comb begin
    gas_need_div = 1'b0;
    priority if (g_max <= g_min) begin
      gas_fixed = (g_delta >= g_min) ? GAS_LEVEL_FULL : '0;
    end else if (g_delta <= g_min) begin
      gas_fixed = '0;
    end else if (g_delta >= g_max) begin
      gas_fixed = GAS_LEVEL_FULL;
    end else begin
      gas_fixed    = '0;
      gas_need_div = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ld_out     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          div_start  = 1'b1;
          div_num    = DIV_NUM_W'(sum_mag);
          div_den    = DIV_DEN_W'(pop_data.cnt);
          state_next = BK_PDIV;
        end
      end
      BK_PDIV: begin
        if (div_done) begin
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        state_next = BK_SCALE;
      end
      BK_SCALE: begin
        if (blow_new && gas_need_div) begin
          div_start  = 1'b1;
          div_num    = DIV_NUM_W'(gas_num);
          div_den    = DIV_DEN_W'(g_max - g_min);
          state_next = BK_GDIV;
        end else begin
          state_next = BK_DONE;
        end
      end
      BK_GDIV: begin
        if (div_done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || results.ready) begin
          ld_out     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid) begin
      neg   <= pop_data.sum[SUM_W-1];
      gas_r <= pop_data.gas;
    end
    if (state == BK_PDIV && div_done) begin
      avg <= neg ? -$signed(quo_p) : $signed(quo_p);
    end
    if (state == BK_MUL) begin
      prod <= PROD_W'(avg) * $signed(PROD_W'({1'b0, cfg.pressure_gain}));
    end
    if (state == BK_SCALE) begin
      filtered <= sat ? sat_val : shifted[LEVEL_W-1:0];
      gas_lvl  <= gas_fixed;
    end
    if (state == BK_GDIV && div_done) begin
      gas_lvl <= div_quo[GLVL_W-1:0];
    end
  end

  // Run counter and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      above_run <= '0;
      blow_flag <= 1'b0;
    end else if (state == BK_SCALE) begin
      above_run <= run_new;
      blow_flag <= blow_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      results.blowing        <= blow_flag;
      results.pressure_level <= blow_flag ? filtered : '0;
      results.gas_level      <= blow_flag ? gas_lvl : '0;
    end
  end

  assign results.valid = out_valid;

endmodule
`default_nettype wire

// File: bench/tb_breath_pressure_detector.sv
`default_nettype none
module tb_breath_pressure_detector;
  import bpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          PHASES        = 12;
  localparam int          SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam longint      LEVEL_HI      = (longint'(1) << (LEVEL_W - 1)) - 1;
  localparam longint      LEVEL_LO      = -(longint'(1) << (LEVEL_W - 1));

  // Index past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic                      blowing;
    logic signed [LEVEL_W-1:0] pressure_level;
    logic [GLVL_W-1:0]         gas_level;
  } reading_t;

  typedef enum int {
    SET_WIDE_OPEN,
    SET_SHUT,
    SET_FLAT_GAS,
    SET_LONG_RUN,
    SET_RANDOM
  } setting_e;

  // Tracks the detector state and the readings still owed by the block
  class breath_tracker;
    bpd_cfg_t regs;
    int       deltas [WINDOW_LEN];
    int       delta_sum;
    int       slot;
    bit       full;
    int       run_len;
    bit       blow;
    reading_t pending_readings [$];
    int       mismatches;

    function new();
      // register defaults after reset
      regs = '{pressure_baseline: '0, pressure_gain: 16'd14855,
               pressure_threshold: 20'd256, stable_required: 8'd5,
               gas_baseline: '0, gas_delta_min: 12'd30, gas_delta_max: 12'd800};
      foreach (deltas[i]) deltas[i] = 0;
      delta_sum  = 0;
      slot       = 0;
      full       = 1'b0;
      run_len    = 0;
      blow       = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PRESSURE_BASELINE:  regs.pressure_baseline  = data[BASE_W-1:0];
        CFG_PRESSURE_GAIN:      regs.pressure_gain      = data[GAIN_W-1:0];
        CFG_PRESSURE_THRESHOLD: regs.pressure_threshold = data[THR_W-1:0];
        CFG_STABLE_REQUIRED:    regs.stable_required    = data[STABLE_W-1:0];
        CFG_GAS_BASELINE:       regs.gas_baseline       = data[BASE_W-1:0];
        CFG_GAS_DELTA_MIN:      regs.gas_delta_min      = data[BASE_W-1:0];
        CFG_GAS_DELTA_MAX:      regs.gas_delta_max      = data[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    // Linear map of the gas delta onto 0..100
    function logic [GLVL_W-1:0] gas_percent(logic [SAMPLE_BITS-1:0] gs);
      int d;
      int lo;
      int hi;
      d  = int'(gs) - int'(regs.gas_baseline);
      if (d < 0) d = 0;
      lo = int'(regs.gas_delta_min);
      hi = int'(regs.gas_delta_max);
      // degenerate span: step at the lower bound
      if (hi <= lo) return (d >= lo) ? GAS_LEVEL_FULL : '0;
      if (d <= lo) return '0;
      if (d >= hi) return GAS_LEVEL_FULL;
      return GLVL_W'((d - lo) * int'(GAS_LEVEL_FULL) / (hi - lo));
    endfunction

    // Advance the window and run counter for one request, queue its reading
    function void take_sample(logic [SAMPLE_BITS-1:0] ps, logic [SAMPLE_BITS-1:0] gs);
      int       delta;
      int       count;
      int       avg;
      int       level;
      longint   scaled;
      reading_t r;
      delta         = int'(ps) - int'(regs.pressure_baseline);
      delta_sum     = delta_sum - deltas[slot] + delta;
      deltas[slot]  = delta;
      slot++;
      if (slot >= WINDOW_LEN) begin
        slot = 0;
        full = 1'b1;
      end
      // divisor follows the fill level until the window wraps
      count = full ? WINDOW_LEN : slot;
      if (count < 1) count = 1;
      avg    = delta_sum / count;
      scaled = (longint'(avg) * longint'(regs.pressure_gain)) >>> 8;
      if (scaled > LEVEL_HI) scaled = LEVEL_HI;
      if (scaled < LEVEL_LO) scaled = LEVEL_LO;
      level = int'(scaled);
      // debounce: saturating run length, cleared at or below threshold
      if (longint'(level) > longint'(regs.pressure_threshold)) begin
        if (run_len < int'(regs.stable_required)) run_len++;
        if (run_len >= int'(regs.stable_required)) blow = 1'b1;
      end else begin
        run_len = 0;
        blow    = 1'b0;
      end
      r.blowing        = blow;
      r.pressure_level = blow ? level[LEVEL_W-1:0] : '0;
      r.gas_level      = blow ? gas_percent(gs) : '0;
      pending_readings.push_back(r);
    endfunction

    function void check_reading(logic b, logic signed [LEVEL_W-1:0] p,
                                logic [GLVL_W-1:0] g);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: blowing %0b pressure_level %0d gas_level %0d", b, p, g);
        mismatches++;
        return;
      end
      want = pending_readings.pop_front();
      if (b !== want.blowing) begin
        $error("blowing: expected %0b, got %0b", want.blowing, b);
        mismatches++;
      end
      if (p !== want.pressure_level) begin
        $error("pressure_level: expected %0d, got %0d", want.pressure_level, p);
        mismatches++;
      end
      if (g !== want.gas_level) begin
        $error("gas_level: expected %0d, got %0d", want.gas_level, g);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  breath_tracker tracker = new();

  always #6 clk = ~clk;

  bpd_in_if  samples_if ();
  bpd_out_if results_if ();
  bpd_cfg_if cfg_if ();

  breath_pressure_detector DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Random back-pressure on the result side
  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every accepted reading
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      tracker.check_reading(results_if.blowing, results_if.pressure_level,
                            results_if.gas_level);
  end

  function automatic logic [SAMPLE_BITS-1:0] to_sample(int v);
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // One request, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] ps,
                             input logic [SAMPLE_BITS-1:0] gs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid           <= 1'b1;
    samples_if.pressure_sample <= ps;
    samples_if.gas_sample      <= gs;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    tracker.take_sample(ps, gs);
  endtask

  // Hold off until every reading is in, then let the back end go quiet
  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    // junk above the register width must be ignored
    if ($urandom_range(0, 1) == 1)
      value = value | (junk & ~((CFG_DATA_W'(1) << width) - 1));
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.set_reg(idx, value);
  endtask

  task automatic configure(input setting_e kind);
    bpd_cfg_t s;
    int       target;
    case (kind)
      SET_WIDE_OPEN: begin
        s = '{pressure_baseline: '0, pressure_gain: '1, pressure_threshold: '0,
              stable_required: 8'd1, gas_baseline: '0, gas_delta_min: '0,
              gas_delta_max: '1};
      end
      SET_SHUT: begin
        s = '{pressure_baseline: '1, pressure_gain: '0, pressure_threshold: '1,
              stable_required: '1, gas_baseline: '1, gas_delta_min: '1,
              gas_delta_max: '0};
      end
      SET_FLAT_GAS: begin
        // zero run length and an empty gas span
        s = '{pressure_baseline: 12'd2048, pressure_gain: 16'd14855,
              pressure_threshold: 20'd100, stable_required: 8'd0,
              gas_baseline: 12'd1000, gas_delta_min: 12'd500, gas_delta_max: 12'd500};
      end
      SET_LONG_RUN: begin
        s = '{pressure_baseline: '0, pressure_gain: '1, pressure_threshold: '0,
              stable_required: '1, gas_baseline: '0, gas_delta_min: '1,
              gas_delta_max: '1};
      end
      default: begin
        s.pressure_baseline = ($urandom_range(0, 9) == 0) ? '0 :
                              BASE_W'($urandom_range(0, 3500));
        s.pressure_gain     = ($urandom_range(0, 9) == 0) ? '1 :
                              GAIN_W'($urandom_range(1, 65535));
        // threshold tied to a reachable average most of the time
        target = $urandom_range(0, 400);
        s.pressure_threshold = ($urandom_range(0, 9) == 0) ? THR_W'($urandom()) :
                               THR_W'((target * int'(s.pressure_gain)) >>> 8);
        s.stable_required = ($urandom_range(0, 7) == 0) ?
                            STABLE_W'($urandom_range(0, 255)) :
                            STABLE_W'($urandom_range(1, 10));
        s.gas_baseline  = BASE_W'($urandom_range(0, 2000));
        s.gas_delta_min = BASE_W'($urandom_range(0, 1500));
        s.gas_delta_max = ($urandom_range(0, 7) == 0) ? BASE_W'($urandom_range(0, 4095)) :
                          BASE_W'($urandom_range(int'(s.gas_delta_min) + 1, 4095));
      end
    endcase
    write_reg(CFG_PRESSURE_BASELINE,  CFG_DATA_W'(s.pressure_baseline),  BASE_W);
    write_reg(CFG_PRESSURE_GAIN,      CFG_DATA_W'(s.pressure_gain),      GAIN_W);
    write_reg(CFG_PRESSURE_THRESHOLD, CFG_DATA_W'(s.pressure_threshold), THR_W);
    write_reg(CFG_STABLE_REQUIRED,    CFG_DATA_W'(s.stable_required),    STABLE_W);
    write_reg(CFG_GAS_BASELINE,       CFG_DATA_W'(s.gas_baseline),       BASE_W);
    write_reg(CFG_GAS_DELTA_MIN,      CFG_DATA_W'(s.gas_delta_min),      BASE_W);
    write_reg(CFG_GAS_DELTA_MAX,      CFG_DATA_W'(s.gas_delta_max),      BASE_W);
    write_reg(CFG_UNUSED,             CFG_DATA_W'($urandom()),           CFG_DATA_W);
    cfg_if.valid <= 1'b0;
  endtask

  // Breaths of random length and strength between rests near the baseline,
  // with some plain noise mixed in
  task automatic breathe(input int n);
    int                     breath_left;
    int                     rest_left;
    int                     lift;
    int                     base;
    int                     v;
    logic [SAMPLE_BITS-1:0] ps;
    logic [SAMPLE_BITS-1:0] gs;
    breath_left = 0;
    rest_left   = 0;
    lift        = 0;
    repeat (n) begin
      base = int'(tracker.regs.pressure_baseline);
      if (breath_left == 0 && rest_left == 0) begin
        breath_left = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 300) :
                      $urandom_range(1, 40);
        lift        = $urandom_range(0, SAMPLE_MAX - base);
        rest_left   = $urandom_range(1, 20);
      end
      if ($urandom_range(0, 99) < 12) begin
        v = $urandom_range(0, SAMPLE_MAX);
      end else if (breath_left > 0) begin
        v = base + lift + $urandom_range(0, 8) - 4;
        breath_left--;
      end else begin
        v = base + $urandom_range(0, 8) - 4;
        rest_left--;
      end
      ps = to_sample(v);
      // half full range, half around the mapped gas span
      if ($urandom_range(0, 1) == 1) begin
        gs = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      end else begin
        v  = int'(tracker.regs.gas_baseline) +
             $urandom_range(0, int'(tracker.regs.gas_delta_max) + 40) - 20;
        gs = to_sample(v);
      end
      // now and then drain the block completely
      if ($urandom_range(0, 299) == 0) settle();
      send_sample(ps, gs);
    end
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] gas_probe [7];
    gas_probe = '{0, 30, 31, 415, 799, 800, SAMPLE_MAX};
    samples_if.valid           = 1'b0;
    samples_if.pressure_sample = '0;
    samples_if.gas_sample      = '0;
    cfg_if.valid               = 1'b0;
    cfg_if.index               = '0;
    cfg_if.data                = '0;
    results_if.ready           = 1'b0;
    send_idle_pct              = 16;
    recv_idle_pct              = 47;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: quiet start, full-scale breath to set blowing, gas span probes,
    // then zeros until the average falls back below threshold
    send_sample('0, '0);
    repeat (5) send_sample('1, '1);
    foreach (gas_probe[i]) send_sample('1, gas_probe[i]);
    repeat (WINDOW_LEN) send_sample('0, 12'd415);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p * 3 / PHASES)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      configure((p < int'(SET_RANDOM)) ? setting_e'(p) : SET_RANDOM);
      breathe((p < int'(SET_RANDOM)) ? 120 : 200);
      settle();
    end

    if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_in_if.sv
hw/rtl/bpd_out_if.sv
hw/rtl/bpd_cfg_if.sv
hw/rtl/bpd_front.sv
hw/rtl/bpd_fifo.sv
hw/rtl/bpd_div.sv
hw/rtl/bpd_back.sv
hw/rtl/breath_pressure_detector.sv
bench/tb_breath_pressure_detector.sv
